FILE: rtl/core/dkt_pkg.sv
// Package for the device key table: sizes, request and status codes, shared types.
// No dependencies.
package dkt_pkg;
  localparam int ENTRIES = 32;
  localparam int DESC_BYTES = 256;
  localparam int ENTRY_W = $clog2(ENTRIES);
  localparam int BYTE_W = $clog2(DESC_BYTES);
  localparam int MEM_DEPTH = ENTRIES * DESC_BYTES;
  localparam int MEM_AW = $clog2(MEM_DEPTH);

  localparam logic [2:0] REQ_ADD = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_FIND = 3'd2;
  localparam logic [2:0] REQ_STORE = 3'd3;
  localparam logic [2:0] REQ_READ = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BADARG = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [2:0] req_type;
    logic [6:0] bus_number;
    logic [6:0] device_address;
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [2:0] link_speed;
    logic [7:0] byte_index;
    logic [7:0] byte_value;
    logic byte_last;
    logic [8:0] read_limit;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] found_bus;
    logic [6:0] found_address;
    logic [8:0] desc_length;
    logic [7:0] read_byte;
  } rsp_t;

  // Search token that travels down the row of cells, one cell per cycle.
  typedef struct packed {
    logic active;
    logic key_hit;
    logic [ENTRY_W-1:0] key_idx;
    logic free_hit;
    logic [ENTRY_W-1:0] free_idx;
    logic find_hit;
    logic [6:0] find_bus;
    logic [6:0] find_addr;
    logic [8:0] key_len;
  } token_t;

  // Update command broadcast from the controller to one cell.
  typedef struct packed {
    logic en;
    logic [ENTRY_W-1:0] idx;
    logic set_used;
    logic clr_used;
    logic new_key;
    logic set_info;
    logic set_len;
    logic clr_len;
    logic [8:0] len;
  } upd_t;
endpackage

FILE: rtl/core/dkt_if.sv
// Valid/ready channel interface carrying one word of payload.
// Depends on dkt_pkg for the payload types.
interface dkt_req_if (input logic clk);
  logic valid;
  logic ready;
  dkt_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dkt_rsp_if (input logic clk);
  logic valid;
  logic ready;
  dkt_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/device_key_table_with_descriptors.sv
// Top level of the device key table: row of entry cells plus the sequencer.
// Depends on dkt_pkg, dkt_if, dkt_cell, dkt_ctrl and dkt_ram.
//
// Requests come in as words on the req channel; each produces exactly one
// response word on the rsp channel. A request is taken when the block is
// idle and its previous response has been taken. In the cycle after the
// accept a search token enters the row of ENTRIES cells and walks it, one
// cell per clock, collecting the key match, the lowest free slot and the
// lowest find match. At the end of the row the sequencer applies the update
// and accesses the descriptor RAM, whose read is registered. The response
// delay is set by the token walk along the cell row. One request is in
// flight at a time, so a new request is taken only after the previous
// response has been taken.
// Reset clears every used flag, so the table starts empty; other entry
// fields and descriptor bytes are undefined until written. While the
// receiver stalls the response word holds and no new request is accepted.
module device_key_table_with_descriptors (
  input logic clk,
  input logic rst,
  dkt_req_if.sink req,
  dkt_rsp_if.source rsp
);
  import dkt_pkg::*;

  req_t cur;
  upd_t upd;
  token_t chain [ENTRIES+1];

  dkt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
    .req(cur), .tok_start(chain[0]), .tok_end(chain[ENTRIES]), .upd(upd),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    dkt_cell u_cell (
      .clk(clk), .rst(rst), .my_idx(ENTRY_W'(i)), .req(cur), .upd(upd),
      .tin(chain[i]), .tout(chain[i+1])
    );
  end
endmodule

FILE: rtl/core/dkt_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module dkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/core/dkt_cell.sv
// One table entry: holds its key and info, matches the request, passes a token on.
// Depends on dkt_pkg.
module dkt_cell (
  input  logic clk,
  input  logic rst,
  input  logic [dkt_pkg::ENTRY_W-1:0] my_idx,
  input  dkt_pkg::req_t req,
  input  dkt_pkg::upd_t upd,
  input  dkt_pkg::token_t tin,
  output dkt_pkg::token_t tout
);
  import dkt_pkg::*;

  logic used;
  logic [6:0] bus;
  logic [6:0] addr;
  logic [15:0] vendor;
  logic [15:0] product;
  logic [8:0] len;
  logic me;
  logic key_m;
  logic find_m;
  token_t t;

  assign me = upd.en && (upd.idx == my_idx);
  assign key_m = used && bus == req.bus_number && addr == req.device_address;
  assign find_m = used && vendor == req.vendor_id &&
                  (req.product_id == 16'd0 || product == req.product_id);

  always_comb begin
    t = tin;
    if (!tin.key_hit && key_m) begin
      t.key_hit = 1'b1;
      t.key_idx = my_idx;
      t.key_len = len;
    end
    if (!tin.free_hit && !used) begin
      t.free_hit = 1'b1;
      t.free_idx = my_idx;
    end
    if (!tin.find_hit && find_m) begin
      t.find_hit = 1'b1;
      t.find_bus = bus;
      t.find_addr = addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      tout.active <= 1'b0;
    end else begin
      tout.active <= tin.active;
      if (me && upd.set_used) used <= 1'b1;
      if (me && upd.clr_used) used <= 1'b0;
    end
    tout.key_hit <= t.key_hit;
    tout.key_idx <= t.key_idx;
    tout.free_hit <= t.free_hit;
    tout.free_idx <= t.free_idx;
    tout.find_hit <= t.find_hit;
    tout.find_bus <= t.find_bus;
    tout.find_addr <= t.find_addr;
    tout.key_len <= t.key_len;
    if (me && upd.new_key) begin
      bus <= req.bus_number;
      addr <= req.device_address;
    end
    if (me && upd.set_info) begin
      vendor <= req.vendor_id;
      product <= req.product_id;
    end
    if (me && upd.clr_len) len <= 9'd0;
    if (me && upd.set_len) len <= upd.len;
  end
endmodule

FILE: rtl/core/dkt_ctrl.sv
// Request sequencer: launches the search token, applies the update, builds the word.
// Depends on dkt_pkg and dkt_ram.
module dkt_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  dkt_pkg::req_t in_data,
  output dkt_pkg::req_t req,
  output dkt_pkg::token_t tok_start,
  input  dkt_pkg::token_t tok_end,
  output dkt_pkg::upd_t upd,
  output logic out_valid,
  input  logic out_ready,
  output dkt_pkg::rsp_t out_data
);
  import dkt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MEM = 2'd2;

  logic [1:0] state;
  logic launch;
  logic mem_we;
  logic [MEM_AW-1:0] mem_addr;
  logic [7:0] mem_rdata;
  logic byte_ok;
  rsp_t rsp;
  logic [8:0] dlen;
  logic ok_idx;

  assign in_ready = state == S_IDLE && !out_valid;
  assign ok_idx = {1'b0, req.byte_index} < 9'(DESC_BYTES);

  // The token enters the row in the cycle after the accept, once req holds the new word.
  always_comb begin
    tok_start = '0;
    tok_start.active = launch;
  end

  assign dlen = (tok_end.key_len < req.read_limit) ? tok_end.key_len : req.read_limit;
  assign mem_addr = MEM_AW'({tok_end.key_idx, req.byte_index[BYTE_W-1:0]});

  always_comb begin
    upd = '0;
    upd.idx = tok_end.key_idx;
    mem_we = 1'b0;
    rsp = '0;
    rsp.status = ST_BADARG;
    case (req.req_type)
      REQ_ADD: begin
        if (req.device_address == 7'd0) begin
          rsp.status = ST_BADARG;
        end else if (tok_end.key_hit) begin
          upd.en = 1'b1;
          upd.set_info = 1'b1;
          rsp.status = ST_OK;
        end else if (tok_end.free_hit) begin
          upd.en = 1'b1;
          upd.idx = tok_end.free_idx;
          upd.set_used = 1'b1;
          upd.new_key = 1'b1;
          upd.set_info = 1'b1;
          upd.clr_len = 1'b1;
          rsp.status = ST_OK;
        end else begin
          rsp.status = ST_FULL;
        end
      end
      REQ_REMOVE: begin
        rsp.status = tok_end.key_hit ? ST_OK : ST_NOTFOUND;
        upd.en = tok_end.key_hit;
        upd.clr_used = 1'b1;
      end
      REQ_FIND: begin
        if (tok_end.find_hit) begin
          rsp.status = ST_OK;
          rsp.found_bus = tok_end.find_bus;
          rsp.found_address = tok_end.find_addr;
        end else begin
          rsp.status = ST_NOTFOUND;
        end
      end
      REQ_STORE: begin
        if (!tok_end.key_hit) begin
          rsp.status = ST_NOTFOUND;
        end else if (!ok_idx) begin
          rsp.status = ST_BADARG;
        end else begin
          rsp.status = ST_OK;
          mem_we = 1'b1;
          upd.en = req.byte_last;
          upd.set_len = 1'b1;
          upd.len = {1'b0, req.byte_index} + 9'd1;
        end
      end
      REQ_READ: begin
        if (!tok_end.key_hit) begin
          rsp.status = ST_NOTFOUND;
        end else if (req.read_limit == 9'd0) begin
          rsp.status = ST_BADARG;
        end else begin
          rsp.status = ST_OK;
          rsp.desc_length = dlen;
        end
      end
      default: rsp.status = ST_BADARG;
    endcase
    if (!(state == S_SCAN && tok_end.active)) begin
      upd.en = 1'b0;
      mem_we = 1'b0;
    end
  end

  dkt_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(req.byte_value), .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      launch <= 1'b0;
    end else begin
      launch <= state == S_IDLE && in_valid && in_ready;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) state <= S_SCAN;
        S_SCAN: if (tok_end.active) begin
          state <= S_MEM;
        end
        S_MEM: begin
          state <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
    if (state == S_IDLE && in_valid && in_ready) req <= in_data;
    if (state == S_SCAN && tok_end.active) begin
      out_data <= rsp;
      byte_ok <= req.req_type == REQ_READ && rsp.status == ST_OK &&
                 {1'b0, req.byte_index} < dlen;
    end
    if (state == S_MEM) out_data.read_byte <= byte_ok ? mem_rdata : 8'd0;
  end
endmodule

FILE: bench/device_key_table_with_descriptors_tb.sv
// Testbench for the device key table: directed and random requests with a
// predictor of the table and descriptor bytes, checked word by word.
// Depends on dkt_pkg, dkt_if and the device_key_table_with_descriptors RTL.
`timescale 1ns / 100ps

module device_key_table_with_descriptors_tb;
  import dkt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 60;

  logic clk;
  logic rst;

  dkt_req_if req (.clk(clk));
  dkt_rsp_if rsp (.clk(clk));

  device_key_table_with_descriptors dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Model of the table contents.
  bit tbl_used [ENTRIES];
  logic [6:0] tbl_bus [ENTRIES];
  logic [6:0] tbl_addr [ENTRIES];
  logic [15:0] tbl_vendor [ENTRIES];
  logic [15:0] tbl_product [ENTRIES];
  logic [8:0] tbl_len [ENTRIES];
  logic [7:0] desc_bytes [ENTRIES][DESC_BYTES];
  bit desc_written [ENTRIES][DESC_BYTES];

  rsp_t pending_rsp [$];
  int mismatches;
  int words_sent;
  int words_checked;
  int cycles;
  bit no_gaps;
  int rsp_hold;

  // Small key and vendor pools so that random requests mostly hit entries.
  logic [6:0] pool_bus [16];
  logic [6:0] pool_addr [16];
  logic [15:0] pool_vendor [4];
  logic [15:0] pool_product [4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words pending", cycles, pending_rsp.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int lookup(logic [6:0] b, logic [6:0] a);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_used[i] && tbl_bus[i] == b && tbl_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic rsp_t predict_table(req_t r);
    rsp_t o;
    int e;
    int len;
    o = '0;
    o.status = ST_BADARG;
    case (r.req_type)
      REQ_ADD: begin
        if (r.device_address != 0) begin
          e = lookup(r.bus_number, r.device_address);
          if (e < 0) begin
            for (int i = 0; i < ENTRIES; i++)
              if (!tbl_used[i]) begin
                e = i;
                break;
              end
            if (e >= 0) begin
              tbl_used[e] = 1'b1;
              tbl_bus[e] = r.bus_number;
              tbl_addr[e] = r.device_address;
              tbl_len[e] = '0;
            end
          end
          if (e < 0) begin
            o.status = ST_FULL;
          end else begin
            tbl_vendor[e] = r.vendor_id;
            tbl_product[e] = r.product_id;
            o.status = ST_OK;
          end
        end
      end
      REQ_REMOVE: begin
        e = lookup(r.bus_number, r.device_address);
        if (e < 0) o.status = ST_NOTFOUND;
        else begin
          tbl_used[e] = 1'b0;
          o.status = ST_OK;
        end
      end
      REQ_FIND: begin
        o.status = ST_NOTFOUND;
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_used[i] && tbl_vendor[i] == r.vendor_id &&
              (r.product_id == 0 || tbl_product[i] == r.product_id)) begin
            o.found_bus = tbl_bus[i];
            o.found_address = tbl_addr[i];
            o.status = ST_OK;
            break;
          end
        end
      end
      REQ_STORE: begin
        e = lookup(r.bus_number, r.device_address);
        if (e < 0) o.status = ST_NOTFOUND;
        else if (int'(r.byte_index) >= DESC_BYTES) o.status = ST_BADARG;
        else begin
          desc_bytes[e][r.byte_index] = r.byte_value;
          desc_written[e][r.byte_index] = 1'b1;
          if (r.byte_last) tbl_len[e] = r.byte_index + 9'd1;
          o.status = ST_OK;
        end
      end
      REQ_READ: begin
        e = lookup(r.bus_number, r.device_address);
        if (e < 0) o.status = ST_NOTFOUND;
        else if (r.read_limit == 0) o.status = ST_BADARG;
        else begin
          len = (tbl_len[e] < r.read_limit) ? tbl_len[e] : r.read_limit;
          o.desc_length = len[8:0];
          if (int'(r.byte_index) < len) o.read_byte = desc_bytes[e][r.byte_index];
          o.status = ST_OK;
        end
      end
      default: o.status = ST_BADARG;
    endcase
    return o;
  endfunction

  // A read below the length must land on a byte that was stored at some point.
  function automatic req_t make_read_safe(req_t r);
    int e;
    int len;
    e = lookup(r.bus_number, r.device_address);
    if (r.req_type != REQ_READ || e < 0 || r.read_limit == 0) return r;
    len = (tbl_len[e] < r.read_limit) ? tbl_len[e] : r.read_limit;
    if (int'(r.byte_index) >= len || desc_written[e][r.byte_index]) return r;
    for (int i = 0; i < len; i++)
      if (desc_written[e][i]) begin
        r.byte_index = i[7:0];
        return r;
      end
    // Length 256 only comes from a last byte at 255, so that byte exists.
    r.byte_index = (len <= 255) ? 8'd255 : 8'd255;
    return r;
  endfunction

  function automatic int draw_gap();
    if (no_gaps) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic send_word(req_t r);
    int gap;
    r = make_read_safe(r);
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
    @(negedge clk);
    req.data <= r;
    req.valid <= 1'b1;
    do @(posedge clk); while (!req.ready);
    pending_rsp.push_back(predict_table(r));
    words_sent++;
  endtask

  // Response ready: a random wait before each word, or a long hold on request.
  initial begin
    int wait_n;
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      wait_n = draw_gap();
      if (rsp_hold > 0) begin
        wait_n = rsp_hold;
        rsp_hold = 0;
      end
      repeat (wait_n) begin
        @(negedge clk);
        rsp.ready <= 1'b0;
      end
      @(negedge clk);
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!(rsp.valid && rsp.ready));
    end
  end

  always @(posedge clk) begin
    rsp_t exp_w;
    if (!rst && rsp.valid && rsp.ready) begin
      words_checked++;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected response word %p", rsp.data);
      end else begin
        exp_w = pending_rsp.pop_front();
        if (rsp.data.status !== exp_w.status || rsp.data.found_bus !== exp_w.found_bus ||
            rsp.data.found_address !== exp_w.found_address ||
            rsp.data.desc_length !== exp_w.desc_length ||
            rsp.data.read_byte !== exp_w.read_byte) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch on word %0d: expected %p, got %p", words_checked, exp_w,
                     rsp.data);
        end
      end
    end
  end

  function automatic req_t noise_word();
    req_t r;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    if (r.read_limit > 256) r.read_limit = 9'($urandom_range(0, 256));
    return r;
  endfunction

  function automatic req_t make_word(logic [2:0] t, logic [6:0] b, logic [6:0] a);
    req_t r;
    r = noise_word();
    r.req_type = t;
    r.bus_number = b;
    r.device_address = a;
    return r;
  endfunction

  task automatic test_directed();
    req_t r;
    r = make_word(REQ_ADD, 7'd5, 7'd0);
    send_word(r);
    send_word(make_word(REQ_REMOVE, 7'd5, 7'd9));
    r = make_word(REQ_FIND, 7'd0, 7'd0);
    send_word(r);
    send_word(make_word(REQ_STORE, 7'd127, 7'd127));
    r = make_word(REQ_READ, 7'd127, 7'd127);
    r.read_limit = 9'd0;
    send_word(r);
    r = make_word(REQ_ADD, 7'd127, 7'd127);
    r.vendor_id = 16'hffff;
    r.product_id = 16'hffff;
    r.link_speed = 3'd7;
    send_word(r);
    r = make_word(REQ_ADD, 7'd0, 7'd1);
    r.vendor_id = 16'h0000;
    r.product_id = 16'h0000;
    r.link_speed = 3'd0;
    send_word(r);
    r = make_word(REQ_STORE, 7'd127, 7'd127);
    r.byte_index = 8'd0;
    r.byte_value = 8'hff;
    r.byte_last = 1'b0;
    send_word(r);
    r = make_word(REQ_STORE, 7'd127, 7'd127);
    r.byte_index = 8'd255;
    r.byte_value = 8'h00;
    r.byte_last = 1'b1;
    send_word(r);
    r = make_word(REQ_READ, 7'd127, 7'd127);
    r.read_limit = 9'd0;
    send_word(r);
    r.read_limit = 9'd256;
    r.byte_index = 8'd255;
    send_word(r);
    r.read_limit = 9'd1;
    r.byte_index = 8'd0;
    send_word(r);
    r.byte_index = 8'd1;
    send_word(r);
    // Adding an existing key keeps its descriptor length.
    r = make_word(REQ_ADD, 7'd127, 7'd127);
    r.vendor_id = 16'h1234;
    r.product_id = 16'h5678;
    send_word(r);
    r = make_word(REQ_READ, 7'd127, 7'd127);
    r.read_limit = 9'd256;
    r.byte_index = 8'd0;
    send_word(r);
    r = make_word(REQ_FIND, 7'd0, 7'd0);
    r.vendor_id = 16'h1234;
    r.product_id = 16'h0000;
    send_word(r);
    r.product_id = 16'h5678;
    send_word(r);
    r.product_id = 16'h5679;
    send_word(r);
    send_word(make_word(3'd5, 7'd127, 7'd127));
    send_word(make_word(3'd7, 7'd127, 7'd127));
    send_word(make_word(REQ_REMOVE, 7'd127, 7'd127));
    r = make_word(REQ_READ, 7'd127, 7'd127);
    r.read_limit = 9'd1;
    send_word(r);
    send_word(make_word(REQ_REMOVE, 7'd0, 7'd1));
  endtask

  task automatic test_table_full();
    req_t r;
    no_gaps = 1'b1;
    for (int i = 0; i <= ENTRIES; i++) begin
      r = make_word(REQ_ADD, i[6:0], 7'd64 + i[6:0]);
      send_word(r);
    end
    no_gaps = 1'b0;
    for (int i = 0; i <= ENTRIES; i++) send_word(make_word(REQ_REMOVE, i[6:0], 7'd64 + i[6:0]));
  endtask

  task automatic test_back_pressure();
    rsp_hold = 400;
    for (int i = 0; i < 20; i++) send_word(make_word(REQ_FIND, 7'd0, 7'd0));
  endtask

  task automatic test_random();
    req_t r;
    int k;
    int n;
    int pick;
    for (int i = 0; i < 16; i++) begin
      pool_bus[i] = 7'($urandom);
      pool_addr[i] = 7'($urandom_range(1, 127));
    end
    for (int i = 0; i < 4; i++) begin
      pool_vendor[i] = 16'($urandom);
      pool_product[i] = 16'($urandom);
    end
    while (words_sent < RANDOM_ITEMS + 100) begin
      if ((words_sent / 150) % 3 == 2) no_gaps = 1'b1;
      else no_gaps = 1'b0;
      k = $urandom_range(0, 15);
      r = make_word(REQ_FIND, pool_bus[k], pool_addr[k]);
      if ($urandom_range(0, 19) == 0) begin
        r.bus_number = 7'($urandom);
        r.device_address = 7'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        r.req_type = REQ_ADD;
        r.vendor_id = pool_vendor[$urandom_range(0, 3)];
        r.product_id = pool_product[$urandom_range(0, 3)];
        send_word(r);
      end else if (pick < 28) begin
        r.req_type = REQ_REMOVE;
        send_word(r);
      end else if (pick < 42) begin
        if ($urandom_range(0, 3) != 0) r.vendor_id = pool_vendor[$urandom_range(0, 3)];
        if ($urandom_range(0, 2) == 0) r.product_id = 16'd0;
        else if ($urandom_range(0, 3) != 0) r.product_id = pool_product[$urandom_range(0, 3)];
        send_word(r);
      end else if (pick < 67) begin
        // A descriptor upload: consecutive bytes, the final one marked last, others now and then.
        n = ($urandom_range(0, 30) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 8);
        r.req_type = REQ_STORE;
        for (int j = 0; j < n; j++) begin
          r.byte_index = j[7:0];
          r.byte_value = 8'($urandom);
          r.byte_last = (j == n - 1) || ($urandom_range(0, 15) == 0);
          send_word(r);
        end
      end else if (pick < 95) begin
        r.req_type = REQ_READ;
        r.read_limit = ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 256));
        if ($urandom_range(0, 1) == 0) r.byte_index = 8'($urandom_range(0, 9));
        send_word(r);
      end else begin
        r.req_type = 3'($urandom_range(5, 7));
        send_word(r);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.data = '0;
    cycles = 0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    no_gaps = 1'b0;
    rsp_hold = 0;
    for (int i = 0; i < ENTRIES; i++) tbl_used[i] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_table_full();
    test_back_pressure();
    test_random();

    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests covering add, remove, find, byte store and read,", words_sent);
    $display("a full table and a long response stall; %0d responses checked.", words_checked);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/dkt_pkg.sv
rtl/core/dkt_if.sv
rtl/core/dkt_ram.sv
rtl/core/dkt_cell.sv
rtl/core/dkt_ctrl.sv
rtl/core/device_key_table_with_descriptors.sv
bench/device_key_table_with_descriptors_tb.sv
